// ----- src/slr_pkg.sv -----
package slr_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned STEP_W     = 36;
  localparam int unsigned POS_W      = 37;
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned Q15_SHIFT  = 17;
  localparam int unsigned Q15_W      = 15;
  localparam int unsigned BYTE_SHIFT = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = STEP_W;

  localparam int unsigned MAX_OUT_PER_IN_DEF = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'h1_0000_0000);

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_OUTPUT = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [Q15_W-1:0]           q15_t;

  typedef struct packed {
    logic start;
    logic byte_mode;
  } lerp_ctl_t;

endpackage

// ----- src/stereo_linear_resampler.sv -----
// Stereo linear-interpolation sample-rate converter.
// Input channel: one stereo frame (in_sample_left, in_sample_right) per
// transaction on in_valid/in_ready. Output channel: interpolated frames on
// out_valid/out_ready with out_last_of_run high on the final frame that an
// input frame causes. Configuration: cfg_we with cfg_index and cfg_wdata,
// index 0 is phase_step (4.32), index 1 is byte_output; write while idle.
// One input frame gives 0 to MAX_OUT_PER_IN output frames. A single shared
// multiplier computes left then right, so each output frame takes the states
// S_CHECK, S_MUL_L, S_MUL_R and S_OUT, and an input frame runs from S_IDLE
// through these for each output, then S_CHECK and S_FIN back to S_IDLE, plus
// any time S_OUT holds with the output register full; S_OUT loads each output.
// in_ready is low while a frame is in work; a finished frame waits in the
// output register while the next one is computed, and the sequencer holds
// when the receiver stalls with the register full.
// Reset clears the phase, the stored frame and the registers to their
// defaults; the first frame after reset is only stored.
module stereo_linear_resampler #(
  parameter int unsigned MAX_OUT_PER_IN = slr_pkg::MAX_OUT_PER_IN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  slr_pkg::sample_t                  in_sample_left,
  input  slr_pkg::sample_t                  in_sample_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output slr_pkg::sample_t                  out_left,
  output slr_pkg::sample_t                  out_right,
  output logic                              out_last_of_run,
  input  logic                              cfg_we,
  input  logic [slr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_OUT_PER_IN + 1);
  localparam int unsigned POS_W = slr_pkg::POS_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL_L = 6'b000100,
    S_MUL_R = 6'b001000,
    S_OUT   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [slr_pkg::STEP_W-1:0]    step_r;
  logic                          byte_r;
  logic [POS_W-1:0]              phase_r, phase_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          have_prev_r, have_prev_nxt;
  slr_pkg::sample_t              prev_l_r, prev_r_r, cur_l_r, cur_r_r;
  slr_pkg::sample_t              res_l_r;
  logic                          out_valid_r, out_valid_nxt;
  slr_pkg::sample_t              out_l_r, out_r_r;
  logic                          out_last_r;

  slr_pkg::lerp_ctl_t            lerp_ctl;
  slr_pkg::sample_t              lerp_prev, lerp_cur, lerp_res;
  slr_pkg::q15_t                 q15;
  logic [POS_W-1:0]              phase_adv;
  logic                          below_one;
  logic                          slot_free;
  logic                          last_now;

  assign q15       = phase_r[slr_pkg::FRAC_W-1:slr_pkg::Q15_SHIFT];
  assign phase_adv = phase_r + POS_W'(step_r);
  assign below_one = (phase_r[POS_W-1:slr_pkg::FRAC_W] == '0);
  assign slot_free = !out_valid_r || out_ready;
  assign last_now  = (cnt_r == CNT_W'(MAX_OUT_PER_IN - 1)) ||
                     (phase_adv[POS_W-1:slr_pkg::FRAC_W] != '0);

  assign lerp_ctl.start     = (state_r == S_MUL_L) || (state_r == S_MUL_R);
  assign lerp_ctl.byte_mode = byte_r;
  assign lerp_prev          = (state_r == S_MUL_R) ? prev_r_r : prev_l_r;
  assign lerp_cur           = (state_r == S_MUL_R) ? cur_r_r : cur_l_r;

  slr_lerp u_lerp (
    .clk         (clk),
    .ctl         (lerp_ctl),
    .prev_sample (lerp_prev),
    .cur_sample  (lerp_cur),
    .q15         (q15),
    .result      (lerp_res)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    have_prev_nxt = have_prev_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (have_prev_r && below_one && (cnt_r != CNT_W'(MAX_OUT_PER_IN))) begin
          state_nxt = S_MUL_L;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL_L: state_nxt = S_MUL_R;
      S_MUL_R: state_nxt = S_OUT;
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          phase_nxt     = phase_adv;
          cnt_nxt       = cnt_r + 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_FIN: begin
        if (below_one) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_r - {{(POS_W - slr_pkg::FRAC_W - 1){1'b0}}, 1'b1,
                                 {slr_pkg::FRAC_W{1'b0}}};
        end
        have_prev_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      step_r      <= slr_pkg::STEP_RESET;
      byte_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_FIN) begin
        prev_l_r <= cur_l_r;
        prev_r_r <= cur_r_r;
      end
      if (cfg_we) begin
        case (cfg_index)
          slr_pkg::REG_PHASE_STEP:  step_r <= cfg_wdata;
          slr_pkg::REG_BYTE_OUTPUT: byte_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_l_r <= in_sample_left;
      cur_r_r <= in_sample_right;
    end
    if (state_r == S_MUL_R) begin
      res_l_r <= lerp_res;
    end
    if ((state_r == S_OUT) && slot_free) begin
      out_l_r    <= res_l_r;
      out_r_r    <= lerp_res;
      out_last_r <= last_now;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_left        = out_l_r;
  assign out_right       = out_r_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- src/slr_lerp.sv -----
module slr_lerp (
  input  logic                clk,
  input  slr_pkg::lerp_ctl_t  ctl,
  input  slr_pkg::sample_t    prev_sample,
  input  slr_pkg::sample_t    cur_sample,
  input  slr_pkg::q15_t       q15,
  output slr_pkg::sample_t    result
);

  localparam int unsigned DW = slr_pkg::SAMPLE_W + 1;
  localparam int unsigned PW = DW + slr_pkg::Q15_W + 1;
  localparam int unsigned SW = PW - 15;

  logic signed [DW-1:0]       diff;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       prod_r;
  slr_pkg::sample_t           base_r;
  logic                       byte_r;
  logic signed [SW-1:0]       sum;
  slr_pkg::sample_t           full;

  assign diff = DW'(cur_sample) - DW'(prev_sample);
  assign prod = PW'(diff * $signed({1'b0, q15}));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod_r <= prod;
      base_r <= prev_sample;
      byte_r <= ctl.byte_mode;
    end
  end

  assign sum  = SW'(base_r) + prod_r[PW-1:15];
  assign full = sum[slr_pkg::SAMPLE_W-1:0];

  always_comb begin
    if (byte_r) begin
      result = full >>> slr_pkg::BYTE_SHIFT;
    end else begin
      result = full;
    end
  end

endmodule

// ----- src/slr_checker.sv -----
module slr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input slr_pkg::sample_t out_left,
  input slr_pkg::sample_t out_right,
  input logic             out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) &&
      $stable(out_right) && $stable(out_last_of_run))
    else $error("output transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while frame in work");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> !in_ready)
    else $error("run ended without last frame");

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_left        (out_left),
  .out_right       (out_right),
  .out_last_of_run (out_last_of_run)
);

// ----- bench/tb_stereo_linear_resampler.sv -----
`timescale 1ns / 1ps

module tb_stereo_linear_resampler;
  import slr_pkg::*;

  localparam int unsigned MAX_RUN = MAX_OUT_PER_IN_DEF;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_FRAMES = 43;

  localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(64'h1_0000_0000);
  localparam logic [STEP_W-1:0] STEP_UNITY = STEP_RESET;
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(64'h2000_0000);
  localparam logic [STEP_W-1:0] STEP_MAX   = {STEP_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_frame_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } interp_frame_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               in_sample_left = '0;
  sample_t               in_sample_right = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sample_t               out_left;
  sample_t               out_right;
  logic                  out_last_of_run;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stereo_frame_t pending_frames[$];
  interp_frame_t expected_frames[$];
  int unsigned   frames_queued = 0;
  int unsigned   frames_accepted = 0;
  int unsigned   frames_checked = 0;
  int unsigned   settings_used = 0;
  int unsigned   error_count = 0;
  logic          steady = 1'b0;

  logic [STEP_W-1:0] step_model = STEP_RESET;
  logic              byte_model = 1'b0;
  logic [POS_W-1:0]  pos_model = '0;
  sample_t           prev_left_model = '0;
  sample_t           prev_right_model = '0;
  logic              have_prev_model = 1'b0;

  stereo_linear_resampler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic sample_t interp_sample(sample_t a, sample_t b, logic [Q15_W-1:0] q);
    int diff;
    int prod;
    int val;
    diff = int'(b) - int'(a);
    prod = diff * int'({17'b0, q});
    val = int'(a) + (prod >>> Q15_W);
    if (byte_model) val = val >>> BYTE_SHIFT;
    return sample_t'(val);
  endfunction

  function automatic void predict_frame(sample_t cur_left, sample_t cur_right);
    int unsigned       n;
    logic [Q15_W-1:0]  q;
    interp_frame_t     res;
    n = 0;
    if (have_prev_model) begin
      while (n < MAX_RUN && pos_model < ONE_POS) begin
        q = pos_model[FRAC_W-1:Q15_SHIFT];
        res.left = interp_sample(prev_left_model, cur_left, q);
        res.right = interp_sample(prev_right_model, cur_right, q);
        n++;
        pos_model = pos_model + POS_W'(step_model);
        res.last = !(n < MAX_RUN && pos_model < ONE_POS);
        expected_frames.push_back(res);
      end
    end
    pos_model = (pos_model >= ONE_POS) ? pos_model - ONE_POS : '0;
    prev_left_model = cur_left;
    prev_right_model = cur_right;
    have_prev_model = 1'b1;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return sample_t'(0);
      3: return sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_frame(sample_t l, sample_t r);
    stereo_frame_t f;
    f.left = l;
    f.right = r;
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PHASE_STEP) step_model = data;
    else if (idx == REG_BYTE_OUTPUT) byte_model = data[0];
  endtask

  task automatic set_mode(logic [STEP_W-1:0] step, logic byte_mode);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_BYTE_OUTPUT, CFG_DATA_W'({$urandom, byte_mode}));
    settings_used++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (frames_accepted != frames_queued || expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input side: hold valid and payload until the transaction completes
  always @(posedge clk) begin : driver
    stereo_frame_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_frame(in_sample_left, in_sample_right);
        frames_accepted++;
      end
      if (pending_frames.size() > 0 && (steady || $urandom_range(0, 99) >= 31)) begin
        nxt = pending_frames.pop_front();
        in_valid <= 1'b1;
        in_sample_left <= nxt.left;
        in_sample_right <= nxt.right;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    interp_frame_t exp_frame;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected output frame: left %0d right %0d last %0b",
                 $signed(out_left), $signed(out_right), out_last_of_run);
          error_count++;
        end else begin
          exp_frame = expected_frames.pop_front();
          frames_checked++;
          if (out_left !== exp_frame.left) begin
            $error("out_left: expected %0d, got %0d",
                   $signed(exp_frame.left), $signed(out_left));
            error_count++;
          end
          if (out_right !== exp_frame.right) begin
            $error("out_right: expected %0d, got %0d",
                   $signed(exp_frame.right), $signed(out_right));
            error_count++;
          end
          if (out_last_of_run !== exp_frame.last) begin
            $error("out_last_of_run: expected %0b, got %0b",
                   exp_frame.last, out_last_of_run);
            error_count++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  initial begin : stimulus
    logic [STEP_W-1:0] step;
    logic              byte_mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first frame only stored, unity step
    settings_used++;
    push_frame(sample_t'(0), sample_t'(0));
    push_frame(sample_t'(32767), sample_t'(-32768));
    push_frame(sample_t'(-32768), sample_t'(32767));
    push_frame(sample_t'(-1), sample_t'(0));
    push_frame(sample_t'(0), sample_t'(-1));
    drain();

    // finest step, byte output, spare indexes ignored
    set_mode(STEP_MIN, 1'b1);
    write_reg(REG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(REG_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}));
    push_frame(sample_t'(-32768), sample_t'(32767));
    push_frame(sample_t'(32767), sample_t'(-32768));
    push_frame(sample_t'(32767), sample_t'(32767));
    push_frame(sample_t'(-32768), sample_t'(-32768));
    push_frame(sample_t'(16'h5555), sample_t'(16'hAAAA));
    push_frame(sample_t'(16'hAAAA), sample_t'(16'h5555));
    drain();

    // step too small: run capped, position saturates at zero
    set_mode('0, 1'b0);
    push_frame(sample_t'(32767), sample_t'(-32768));
    push_frame(sample_t'(-32768), sample_t'(32767));
    push_frame(sample_t'(1234), sample_t'(-4321));
    drain();
    set_mode(STEP_MIN - 1, 1'b0);
    push_frame(sample_t'(-32768), sample_t'(32767));
    push_frame(sample_t'(32767), sample_t'(-32768));
    push_frame(sample_t'(-1), sample_t'(1));
    drain();

    // coarsest step: most frames give nothing
    set_mode(STEP_MAX, 1'b1);
    repeat (5) push_frame(rand_sample(), rand_sample());
    drain();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: begin
          step = STEP_UNITY;
          byte_mode = 1'b0;
        end
        1: begin
          step = STEP_MIN;
          byte_mode = 1'b1;
        end
        2: begin
          step = STEP_MAX;
          byte_mode = 1'b0;
        end
        default: begin
          byte_mode = 1'($urandom);
          case ((k == 3) ? 0 : $urandom_range(0, 3))
            0, 1: step = STEP_W'($urandom_range(32'h2000_0000, 32'hFFFF_FFFF));
            2: step = {2'b00, 2'($urandom_range(1, 3)), 32'($urandom)};
            default: begin
              step = {4'($urandom), 32'($urandom)};
              if (step < STEP_MIN) step = step | STEP_MIN;
            end
          endcase
        end
      endcase
      set_mode(step, byte_mode);
      steady = (k == 3);
      repeat (PHASE_FRAMES) push_frame(rand_sample(), rand_sample());
      drain();
      steady = 1'b0;
    end

    $display("Sent %0d input frames, checked %0d output frames", frames_accepted,
             frames_checked);
    $display("over %0d step and output-width settings, 8-bit and 16-bit output",
             settings_used);
    if (error_count == 0) begin
      $display("tb_stereo_linear_resampler: PASS");
    end else begin
      $display("tb_stereo_linear_resampler: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("tb_stereo_linear_resampler: FAIL");
    $finish;
  end

endmodule
